// ----- design/assert_macros.svh -----
// Assertion macros used by the RTL file edge_plane_slicer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- design/eps_pkg.sv -----
// ---------------------------------------------------------------------------
// eps_pkg
// Types and constants for the edge plane slicer.
// ---------------------------------------------------------------------------
package eps_pkg;

   localparam int unsigned PC_W       = 7;
   localparam logic [PC_W-1:0] PC_RESET = 7'd64;
   localparam logic REG_PLANE_COUNT   = 1'b0;

   typedef struct packed {
      logic signed [31:0] xa;
      logic signed [31:0] ya;
      logic signed [31:0] za;
      logic signed [31:0] xb;
      logic signed [31:0] yb;
      logic signed [31:0] zb;
      logic [23:0]        id_a;
      logic [23:0]        id_b;
   } req_type;

   typedef struct packed {
      logic [5:0]         plane_index;
      logic signed [31:0] x;
      logic signed [31:0] y;
      logic signed [31:0] z;
      logic               at_vertex;
      logic [23:0]        vertex_id;
      logic [23:0]        low_id;
      logic [23:0]        high_id;
      logic               last;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_ORDER,
      ST_RANGE,
      ST_CHECK,
      ST_LOAD,
      ST_MUL,
      ST_DIV,
      ST_FIN,
      ST_EMIT
   } state_type;

endpackage

// ----- design/edge_plane_slicer.sv -----
// Sequence: an item taken in idle has its endpoints ordered and its plane range found; then
// each crossing is checked and, when snapped to an endpoint, emitted directly; when it is
// interpolated, each of the 3 coordinates is loaded, multiplied, divided and finished first.
// One edge at a time, up to 64 crossings; a new item is taken only after the last emit. The
// single 34-bit add/subtract unit, stepped for each multiply and divide bit, sets the pace,
// and a stalled result holds the sequencer. Reset: synchronous; sequencer idle, output
// empty, plane_count back to 64.
// ---------------------------------------------------------------------------
// edge_plane_slicer
// Intersects one mesh edge with unit-spaced planes z = 0 .. min(plane_count,MAX_PLANES)-1.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module edge_plane_slicer
   import eps_pkg::*;
#(
   parameter int MAX_PLANES = 64,
   parameter int FRAC_BITS  = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output rsp_type     rsp_data,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int IW = 32 - FRAC_BITS;
   localparam logic [PC_W-1:0] MAXP = PC_W'(MAX_PLANES);
   localparam logic signed [33:0] SNAP = 34'((64'(1) << FRAC_BITS) / 100);

   state_type state_ff, state_in;

   logic [PC_W-1:0]    pc_ff;
   req_type            in_ff;
   logic signed [31:0] lo_x_ff, lo_y_ff, lo_z_ff, hi_x_ff, hi_y_ff, hi_z_ff;
   logic [23:0]        id_lo_ff, id_hi_ff;
   logic [PC_W-1:0]    k_ff, end_ff;
   logic [31:0]        dz_ff, d_ff, mag_ff;
   logic               neg_ff, empty_ff;
   logic signed [31:0] clo_ff;
   logic [63:0]        p_ff;
   logic [4:0]         stp_ff;
   logic [1:0]         crd_ff;
   logic signed [31:0] res_x_ff, res_y_ff, res_z_ff;
   logic               atv_ff;
   logic [23:0]        vid_ff;
   logic               snap_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;

   // configuration port
   logic csr_wr;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[2] == REG_PLANE_COUNT) begin
         csr_prdata = {25'd0, pc_ff};
      end
   end

   // endpoint ordering
   logic a_first;
   always_comb begin
      if (in_ff.za != in_ff.zb) begin
         a_first = in_ff.za < in_ff.zb;
      end else if (in_ff.xa != in_ff.xb) begin
         a_first = in_ff.xa < in_ff.xb;
      end else begin
         a_first = in_ff.ya <= in_ff.yb;
      end
   end

   // plane range
   logic [PC_W-1:0]   cnt, cnt_m1, end_r;
   logic [IW-1:0]     start_w, fl_hi;
   logic signed [IW-1:0] fl_lo;
   logic              frac_nz, empty_r;
   always_comb begin
      cnt     = (pc_ff > MAXP) ? MAXP : pc_ff;
      cnt_m1  = cnt - PC_W'(1);
      fl_lo   = IW'(lo_z_ff >>> FRAC_BITS);
      frac_nz = |lo_z_ff[FRAC_BITS-1:0];
      start_w = (lo_z_ff <= 0) ? '0 : IW'(fl_lo + IW'(frac_nz));
      fl_hi   = IW'(hi_z_ff >>> FRAC_BITS);
      end_r   = (fl_hi < IW'(cnt_m1)) ? fl_hi[PC_W-1:0] : cnt_m1;
      empty_r = (lo_z_ff == hi_z_ff) || hi_z_ff[31] || (cnt == '0) ||
                (start_w > IW'(end_r));
   end

   // snap tests for the current plane
   logic signed [33:0] kz, dlo, dhi;
   logic               snap_lo, snap_hi;
   always_comb begin
      kz      = 34'({k_ff, FRAC_BITS'(0)});
      dlo     = kz - 34'(lo_z_ff);
      dhi     = 34'(hi_z_ff) - kz;
      snap_lo = dlo <= SNAP;
      snap_hi = dhi <= SNAP;
   end

   // coordinate select for interpolation
   logic signed [31:0] c_lo, c_hi;
   logic signed [32:0] c_diff;
   always_comb begin
      case (crd_ff)
         2'd0:    begin c_lo = lo_x_ff; c_hi = hi_x_ff; end
         2'd1:    begin c_lo = lo_y_ff; c_hi = hi_y_ff; end
         default: begin c_lo = lo_z_ff; c_hi = hi_z_ff; end
      endcase
      c_diff = 33'(c_hi) - 33'(c_lo);
   end

   // shared add/subtract unit: multiply accumulate or divide trial subtract
   logic        unit_sub;
   logic [33:0] unit_a, unit_b, unit_sum;
   always_comb begin
      unit_a   = unit_sub ? {1'b0, p_ff[63:31]} : {2'b00, p_ff[63:32]};
      unit_b   = unit_sub ? {2'b00, dz_ff} : {2'b00, mag_ff};
      unit_sum = unit_a + (unit_sub ? ~unit_b : unit_b) + 34'(unit_sub);
   end

   logic        out_free, out_load;
   logic [31:0] res_c;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign res_c    = neg_ff ? clo_ff - p_ff[31:0] : clo_ff + p_ff[31:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_ORDER;
         ST_ORDER: state_in = ST_RANGE;
         ST_RANGE: state_in = empty_r ? ST_IDLE : ST_CHECK;
         ST_CHECK: state_in = (snap_lo || snap_hi) ? ST_EMIT : ST_LOAD;
         ST_LOAD:  state_in = ST_MUL;
         ST_MUL:   if (stp_ff == 5'd31) state_in = ST_DIV;
         ST_DIV:   if (stp_ff == 5'd31) state_in = ST_FIN;
         ST_FIN:   state_in = (crd_ff == 2'd2) ? ST_EMIT : ST_LOAD;
         ST_EMIT: begin
            if (out_free) state_in = (k_ff == end_ff) ? ST_IDLE : ST_CHECK;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_stall = 1'b1;
      unit_sub  = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: req_stall = 1'b0;
         ST_DIV:  unit_sub  = 1'b1;
         ST_EMIT: out_load  = out_free;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pc_ff        <= PC_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_wr && csr_pready && csr_paddr[2] == REG_PLANE_COUNT) begin
            pc_ff <= csr_pwdata[PC_W-1:0];
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) in_ff <= req_data;
         end
         ST_ORDER: begin
            lo_x_ff  <= a_first ? in_ff.xa : in_ff.xb;
            lo_y_ff  <= a_first ? in_ff.ya : in_ff.yb;
            lo_z_ff  <= a_first ? in_ff.za : in_ff.zb;
            hi_x_ff  <= a_first ? in_ff.xb : in_ff.xa;
            hi_y_ff  <= a_first ? in_ff.yb : in_ff.ya;
            hi_z_ff  <= a_first ? in_ff.zb : in_ff.za;
            id_lo_ff <= a_first ? in_ff.id_a : in_ff.id_b;
            id_hi_ff <= a_first ? in_ff.id_b : in_ff.id_a;
         end
         ST_RANGE: begin
            k_ff     <= start_w[PC_W-1:0];
            end_ff   <= end_r;
            empty_ff <= empty_r;
            dz_ff    <= 32'(hi_z_ff - lo_z_ff);
         end
         ST_CHECK: begin
            crd_ff  <= 2'd0;
            d_ff    <= dlo[31:0];
            snap_ff <= snap_lo || snap_hi;
            if (snap_lo) begin
               res_x_ff <= lo_x_ff; res_y_ff <= lo_y_ff; res_z_ff <= lo_z_ff;
               atv_ff   <= 1'b1;    vid_ff   <= id_lo_ff;
            end else if (snap_hi) begin
               res_x_ff <= hi_x_ff; res_y_ff <= hi_y_ff; res_z_ff <= hi_z_ff;
               atv_ff   <= 1'b1;    vid_ff   <= id_hi_ff;
            end else begin
               atv_ff <= 1'b0;
               vid_ff <= '0;
            end
         end
         ST_LOAD: begin
            clo_ff <= c_lo;
            neg_ff <= c_diff[32];
            mag_ff <= c_diff[32] ? 32'(-c_diff) : c_diff[31:0];
            p_ff   <= {32'd0, d_ff};
            stp_ff <= '0;
         end
         ST_MUL: begin
            stp_ff <= stp_ff + 5'd1;
            if (p_ff[0]) begin
               p_ff <= {unit_sum[32:0], p_ff[31:1]};
            end else begin
               p_ff <= {1'b0, p_ff[63:1]};
            end
         end
         ST_DIV: begin
            stp_ff <= stp_ff + 5'd1;
            if (!unit_sum[33]) begin
               p_ff <= {unit_sum[31:0], p_ff[30:0], 1'b1};
            end else begin
               p_ff <= {p_ff[62:0], 1'b0};
            end
         end
         ST_FIN: begin
            crd_ff <= crd_ff + 2'd1;
            case (crd_ff)
               2'd0:    res_x_ff <= res_c;
               2'd1:    res_y_ff <= res_c;
               default: res_z_ff <= res_c;
            endcase
         end
         ST_EMIT: begin
            if (out_free) k_ff <= k_ff + PC_W'(1);
         end
         default: ;
      endcase
      if (out_load) begin
         rsp_ff.plane_index <= k_ff[5:0];
         rsp_ff.x           <= res_x_ff;
         rsp_ff.y           <= res_y_ff;
         rsp_ff.z           <= res_z_ff;
         rsp_ff.at_vertex   <= atv_ff;
         rsp_ff.vertex_id   <= vid_ff;
         rsp_ff.low_id      <= id_lo_ff;
         rsp_ff.high_id     <= id_hi_ff;
         rsp_ff.last        <= (k_ff == end_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   `ASSERT_NEXT(a_mul_to_div, clock, reset, state_ff == ST_MUL && stp_ff == 5'd31,
                state_ff == ST_DIV, "multiply did not hand over to divide")
   `ASSERT_IMPLY(a_quot_bound, clock, reset, state_ff == ST_FIN, p_ff[31:0] <= mag_ff,
                 "quotient exceeds coordinate span")
   `ASSERT_IMPLY(a_k_range, clock, reset, state_ff == ST_CHECK, k_ff <= end_ff && !empty_ff,
                 "plane index past range end")
   `ASSERT_NEXT(a_last_idle, clock, reset, out_load && k_ff == end_ff,
                state_ff == ST_IDLE && rsp_valid, "final crossing did not end the edge")
   `ASSERT_IMPLY(a_snap_id, clock, reset, state_ff == ST_EMIT && !snap_ff,
                 !atv_ff && vid_ff == '0, "interpolated crossing carries a vertex id")

endmodule
